### rtl/positional_list_engine_macros.svh
// Assertion macros for the positional list engine.
// Needs signals named clk and rst_n in the scope of each use.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// Same-cycle implication.
`define PLE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ple_pkg.sv
// Shared types and constants of the positional list engine.
// No dependencies.
package ple_pkg;

    localparam int DEF_CAPACITY = 256;
    localparam int REQ_W        = 3;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 10;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 9;

    typedef enum logic [REQ_W-1:0] {
        REQ_INS_FRONT = 3'd0,
        REQ_INS_BACK  = 3'd1,
        REQ_INS_POS   = 3'd2,
        REQ_DEL_FRONT = 3'd3,
        REQ_DEL_BACK  = 3'd4,
        REQ_DEL_POS   = 3'd5,
        REQ_READ      = 3'd6
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    // One datapath operation per cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,      // capture request
        OP_START_UP,  // ptr = count-1
        OP_START_DN,  // ptr = idx+1
        OP_STEP_UP,   // read ptr, write pending word one slot up, ptr--
        OP_STEP_DN,   // read ptr, write pending word one slot down, ptr++
        OP_FLUSH_UP,  // write last pending word one slot up
        OP_FLUSH_DN,  // write last pending word one slot down, count--
        OP_PUT,       // write new word at idx, count++
        OP_DROP,      // count--
        OP_READ,      // read idx
        OP_TAKE,      // result word = read data
        OP_FAIL,      // result status = code
        OP_DELIVER    // result -> output register
    } op_t;

    typedef struct packed {
        op_t     op;
        status_t code;
    } ple_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             len_zero;
        logic             full;
        logic             ins_pos_ok;
        logic             del_pos_ok;
        logic             idx_at_end;
        logic             idx_is_last;
        logic             ptr_at_idx;
        logic             ptr_at_last;
    } ple_stat_t;

endpackage

### rtl/ple_req_if.sv
// Request channel: valid/ready plus request payload.
// Depends on ple_pkg.
interface ple_req_if
    import ple_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [REQ_W-1:0]          req_type;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;

    modport source (output valid, output req_type, output value, output position,
                    input ready);
    modport sink   (input valid, input req_type, input value, input position,
                    output ready);
endinterface

### rtl/ple_rsp_if.sv
// Response channel: valid/ready plus result payload.
// Depends on ple_pkg.
interface ple_rsp_if
    import ple_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0]        count;

    modport source (output valid, output status, output read_value, output count,
                    input ready);
    modport sink   (input valid, input status, input read_value, input count,
                    output ready);
endinterface

### rtl/positional_list_engine.sv
// Appends, drops and rejected requests need no shift; a shifting insert or delete moves the
// N words behind its target one slot each (N < CAPACITY).
// One request in flight; the next is taken in the cycle after the result is loaded.
// The shift moves one word per cycle through the single-port-write word memory.
// Reset clears the element count and handshake state; list words are not cleared.
// Top level of the positional list engine; depends on ple_pkg, ple_req_if, ple_rsp_if, ple_controller and ple_datapath.
module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input logic       clk,
    input logic       rst_n,
    ple_req_if.sink   req,
    ple_rsp_if.source rsp
);

    // Controller and datapath exchange only the command and status structs.
    ple_cmd_t  cmd;
    ple_stat_t stat;

    // The controller owns both handshakes; results sit in an output register
    // so a waiting response never blocks the sequencer until a new one is due.
    ple_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Word store keeps position p at index p-1; inserts and deletes shift
    // the tail one slot per cycle with a registered read.
    ple_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .req_type   (req.req_type),
        .value      (req.value),
        .position   (req.position),
        .status     (rsp.status),
        .read_value (rsp.read_value),
        .count      (rsp.count)
    );

endmodule

### rtl/ple_datapath.sv
// List datapath: word memory, count, shift pointer and result registers.
// Depends on ple_pkg and the assertion macro header.
`include "positional_list_engine_macros.svh"

module ple_datapath
    import ple_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ple_cmd_t                  cmd,
    output ple_stat_t                 stat,
    input  logic [REQ_W-1:0]          req_type,
    input  logic signed [VALUE_W-1:0] value,
    input  logic [POS_W-1:0]          position,
    output logic [STATUS_W-1:0]       status,
    output logic signed [VALUE_W-1:0] read_value,
    output logic [COUNT_W-1:0]        count
);

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = (LW > POS_W) ? LW : POS_W;

    logic [VALUE_W-1:0]  mem [CAPACITY];

    logic [REQ_W-1:0]    req_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [LW-1:0]       len_reg;
    logic [AW-1:0]       ptr_reg;
    logic                pend_reg;
    logic [AW-1:0]       pend_addr_reg;
    logic [VALUE_W-1:0]  rdata_reg;
    status_t             res_status_reg;
    logic [VALUE_W-1:0]  res_rdata_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [VALUE_W-1:0]  out_rdata_reg;
    logic [COUNT_W-1:0]  out_count_reg;

    logic [POS_W-1:0]    pos_m1;
    logic [CW-1:0]       pos_c;
    logic [CW-1:0]       len_c;
    logic [LW-1:0]       len_m1;
    logic [AW-1:0]       idx;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [VALUE_W-1:0]  wr_data;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;

    assign pos_m1 = pos_reg - POS_W'(1);
    assign pos_c  = CW'(pos_reg);
    assign len_c  = CW'(len_reg);
    assign len_m1 = len_reg - LW'(1);

    // Target index of the request, valid only once its range check passed.
    always_comb
    begin
        case (req_reg)
            REQ_INS_BACK: idx = AW'(len_reg);
            REQ_INS_POS,
            REQ_DEL_POS,
            REQ_READ:     idx = AW'(pos_m1);
            default:      idx = '0;
        endcase
    end

    always_comb
    begin
        stat.req         = req_reg;
        stat.len_zero    = (len_reg == '0);
        stat.full        = (len_reg == LW'(CAPACITY));
        stat.ins_pos_ok  = (pos_reg != '0) && (pos_c <= len_c + CW'(1));
        stat.del_pos_ok  = (pos_reg != '0) && (pos_c <= len_c);
        stat.idx_at_end  = (LW'(idx) == len_reg);
        stat.idx_is_last = (LW'(idx) == len_m1);
        stat.ptr_at_idx  = (ptr_reg == idx);
        stat.ptr_at_last = (LW'(ptr_reg) == len_m1);
    end

    // Memory port selection
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pend_addr_reg + AW'(1);
        wr_data = rdata_reg;
        rd_en   = 1'b0;
        rd_addr = ptr_reg;
        case (cmd.op)
            OP_STEP_UP:
            begin
                wr_en = pend_reg;
                rd_en = 1'b1;
            end
            OP_STEP_DN:
            begin
                wr_en   = pend_reg;
                wr_addr = pend_addr_reg - AW'(1);
                rd_en   = 1'b1;
            end
            OP_FLUSH_UP:
            begin
                wr_en = 1'b1;
            end
            OP_FLUSH_DN:
            begin
                wr_en   = 1'b1;
                wr_addr = pend_addr_reg - AW'(1);
            end
            OP_PUT:
            begin
                wr_en   = 1'b1;
                wr_addr = idx;
                wr_data = value_reg;
            end
            OP_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = idx;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    // Control state: count and pending-word flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= (cmd.op == OP_STEP_UP) || (cmd.op == OP_STEP_DN);
            case (cmd.op)
                OP_PUT:      len_reg <= len_reg + LW'(1);
                OP_DROP,
                OP_FLUSH_DN: len_reg <= len_m1;
                default:     len_reg <= len_reg;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                req_reg        <= req_type;
                value_reg      <= value;
                pos_reg        <= position;
                res_status_reg <= ST_OK;
                res_rdata_reg  <= '0;
            end
            OP_START_UP: ptr_reg <= AW'(len_m1);
            OP_START_DN: ptr_reg <= idx + AW'(1);
            OP_STEP_UP:
            begin
                ptr_reg       <= ptr_reg - AW'(1);
                pend_addr_reg <= ptr_reg;
            end
            OP_STEP_DN:
            begin
                ptr_reg       <= ptr_reg + AW'(1);
                pend_addr_reg <= ptr_reg;
            end
            OP_TAKE: res_rdata_reg  <= rdata_reg;
            OP_FAIL: res_status_reg <= cmd.code;
            OP_DELIVER:
            begin
                out_status_reg <= res_status_reg;
                out_rdata_reg  <= res_rdata_reg;
                out_count_reg  <= COUNT_W'(len_reg);
            end
            default:
            begin
                ptr_reg <= ptr_reg;
            end
        endcase
    end

    assign status     = out_status_reg;
    assign read_value = out_rdata_reg;
    assign count      = out_count_reg;

    `PLE_ASSERT_IMPL(a_len_bound, 1'b1, len_reg <= LW'(CAPACITY), "count above capacity")
    `PLE_ASSERT_IMPL(a_put_not_full, cmd.op == OP_PUT, len_reg != LW'(CAPACITY), "insert when full")
    `PLE_ASSERT_IMPL(a_flush_pending, (cmd.op == OP_FLUSH_UP) || (cmd.op == OP_FLUSH_DN), pend_reg, "flush without pending word")

endmodule

### rtl/ple_controller.sv
// Request sequencer: handshakes and per-cycle datapath commands.
// Depends on ple_pkg and the assertion macro header.
`include "positional_list_engine_macros.svh"

module ple_controller
    import ple_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  ple_stat_t stat,
    output ple_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT_UP,
        S_FLUSH_UP,
        S_PUT,
        S_SHIFT_DN,
        S_FLUSH_DN,
        S_READ_WAIT,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.code   = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FINISH;
                case (stat.req)
                    REQ_INS_FRONT,
                    REQ_INS_BACK,
                    REQ_INS_POS:
                    begin
                        if ((stat.req == REQ_INS_POS) && !stat.ins_pos_ok)
                        begin
                            cmd.op   = OP_FAIL;
                            cmd.code = ST_BADPOS;
                        end
                        else if (stat.full)
                        begin
                            cmd.op   = OP_FAIL;
                            cmd.code = ST_FULL;
                        end
                        else if (stat.idx_at_end)
                            cmd.op = OP_PUT;
                        else
                        begin
                            cmd.op     = OP_START_UP;
                            state_next = S_SHIFT_UP;
                        end
                    end
                    REQ_DEL_FRONT,
                    REQ_DEL_POS:
                    begin
                        if ((stat.req == REQ_DEL_FRONT) && stat.len_zero)
                        begin
                            cmd.op   = OP_FAIL;
                            cmd.code = ST_EMPTY;
                        end
                        else if ((stat.req == REQ_DEL_POS) && !stat.del_pos_ok)
                        begin
                            cmd.op   = OP_FAIL;
                            cmd.code = ST_BADPOS;
                        end
                        else if (stat.idx_is_last)
                            cmd.op = OP_DROP;
                        else
                        begin
                            cmd.op     = OP_START_DN;
                            state_next = S_SHIFT_DN;
                        end
                    end
                    REQ_DEL_BACK:
                    begin
                        if (stat.len_zero)
                        begin
                            cmd.op   = OP_FAIL;
                            cmd.code = ST_EMPTY;
                        end
                        else
                            cmd.op = OP_DROP;
                    end
                    REQ_READ:
                    begin
                        if (!stat.del_pos_ok)
                        begin
                            cmd.op   = OP_FAIL;
                            cmd.code = ST_BADPOS;
                        end
                        else
                        begin
                            cmd.op     = OP_READ;
                            state_next = S_READ_WAIT;
                        end
                    end
                    default:
                    begin
                        cmd.op = OP_NONE;  // unused code: plain ok
                    end
                endcase
            end
            S_SHIFT_UP:
            begin
                cmd.op = OP_STEP_UP;
                if (stat.ptr_at_idx)
                    state_next = S_FLUSH_UP;
            end
            S_FLUSH_UP:
            begin
                cmd.op     = OP_FLUSH_UP;
                state_next = S_PUT;
            end
            S_PUT:
            begin
                cmd.op     = OP_PUT;
                state_next = S_FINISH;
            end
            S_SHIFT_DN:
            begin
                cmd.op = OP_STEP_DN;
                if (stat.ptr_at_last)
                    state_next = S_FLUSH_DN;
            end
            S_FLUSH_DN:
            begin
                cmd.op     = OP_FLUSH_DN;
                state_next = S_FINISH;
            end
            S_READ_WAIT:
            begin
                cmd.op     = OP_TAKE;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op     = OP_DELIVER;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.op == OP_DELIVER)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    `PLE_ASSERT_NEXT(a_accept_decode, in_valid && in_ready, state_reg == S_DECODE, "accept did not start decode")
    `PLE_ASSERT_NEXT(a_up_to_flush, (state_reg == S_SHIFT_UP) && stat.ptr_at_idx, state_reg == S_FLUSH_UP, "shift up overran target")
    `PLE_ASSERT_IMPL(a_deliver_free, cmd.op == OP_DELIVER, !out_valid_reg || out_ready, "result overwritten")

endmodule

### tb/tb_positional_list_engine.sv
// Self-checking testbench for positional_list_engine: directed table, then random list traffic.
// Depends on ple_pkg, ple_req_if, ple_rsp_if and the engine RTL.
module tb_positional_list_engine
    import ple_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = DEF_CAPACITY;

    // Request code that the engine treats as a no-op.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

    // Receiver ready patterns.
    localparam int RX_FREE     = 0;
    localparam int RX_RANDOM   = 1;
    localparam int RX_PERIODIC = 2;

    // Longest shift moves CAPACITY-1 words plus its control steps; the hold-off
    // stretch and sender gaps come on top. The watchdog sits well above all of that.
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = CAPACITY + 16;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DIR_ROWS       = 24;

    typedef struct packed {
        status_t                   status;
        logic signed [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0]        count;
    } list_rsp_t;

    // One row of the directed table. Rows with 'typed' set carry an expected result
    // written by hand; the rest are checked against the shadow list.
    typedef struct {
        logic [REQ_W-1:0]          op;
        logic signed [VALUE_W-1:0] word;
        logic [POS_W-1:0]          pos;
        bit                        typed;
        list_rsp_t                 want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    ple_req_if req_ch ();
    ple_rsp_if rsp_ch ();

    positional_list_engine #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the list contents; position p lives at index p-1.
    logic signed [VALUE_W-1:0] shadow_words [CAPACITY];
    int unsigned               shadow_len;

    // Results owed by the engine, oldest first.
    list_rsp_t awaited_results [$];

    int  mismatches;
    int  results_seen;
    int  burst_left;
    bit  hold_rsp_req;
    bit  hold_done;

    dir_row_t dir_tab [DIR_ROWS];

    //------------------------------------------------------------------
    // Clock
    //------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    //------------------------------------------------------------------
    // Shadow list: shifting insert and remove, as the engine does them
    //------------------------------------------------------------------
    function automatic void shadow_insert(int unsigned idx, logic signed [VALUE_W-1:0] w);
        for (int unsigned i = shadow_len; i > idx; i--)
        begin
            shadow_words[i] = shadow_words[i - 1];
        end
        shadow_words[idx] = w;
        shadow_len++;
    endfunction

    function automatic void shadow_remove(int unsigned idx);
        for (int unsigned i = idx; i + 1 < shadow_len; i++)
        begin
            shadow_words[i] = shadow_words[i + 1];
        end
        shadow_len--;
    endfunction

    // Apply one request to the shadow list and return the result it must produce.
    // Position range is checked before the full check on positional inserts.
    function automatic list_rsp_t predict_list_op(logic [REQ_W-1:0] op,
                                                  logic signed [VALUE_W-1:0] w,
                                                  logic [POS_W-1:0] pos);
        list_rsp_t   r;
        int unsigned p;
        r.status     = ST_OK;
        r.read_value = '0;
        p            = pos;
        case (op)
            REQ_INS_FRONT:
            begin
                if (shadow_len >= CAPACITY) r.status = ST_FULL;
                else shadow_insert(0, w);
            end
            REQ_INS_BACK:
            begin
                if (shadow_len >= CAPACITY) r.status = ST_FULL;
                else shadow_insert(shadow_len, w);
            end
            REQ_INS_POS:
            begin
                if (p < 1 || p > shadow_len + 1) r.status = ST_BADPOS;
                else if (shadow_len >= CAPACITY) r.status = ST_FULL;
                else shadow_insert(p - 1, w);
            end
            REQ_DEL_FRONT:
            begin
                if (shadow_len == 0) r.status = ST_EMPTY;
                else shadow_remove(0);
            end
            REQ_DEL_BACK:
            begin
                if (shadow_len == 0) r.status = ST_EMPTY;
                else shadow_len--;
            end
            REQ_DEL_POS:
            begin
                if (p < 1 || p > shadow_len) r.status = ST_BADPOS;
                else shadow_remove(p - 1);
            end
            REQ_READ:
            begin
                if (p < 1 || p > shadow_len) r.status = ST_BADPOS;
                else r.read_value = shadow_words[p - 1];
            end
            default:
            begin
                // unused code: no effect
            end
        endcase
        r.count = shadow_len[COUNT_W-1:0];
        return r;
    endfunction

    //------------------------------------------------------------------
    // Random content
    //------------------------------------------------------------------
    // Data word: extremes a good share of the time, otherwise any 32-bit pattern.
    function automatic logic signed [VALUE_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh0;
            3: return 32'shFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Request code; ins_pct steers the list toward growing or shrinking.
    function automatic logic [REQ_W-1:0] pick_op(int ins_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            return REQ_UNUSED;
        end
        else if (r < 2 + ins_pct)
        begin
            case ($urandom_range(0, 2))
                0: return REQ_INS_FRONT;
                1: return REQ_INS_BACK;
                default: return REQ_INS_POS;
            endcase
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: return REQ_DEL_FRONT;
                1: return REQ_DEL_BACK;
                2: return REQ_DEL_POS;
                default: return REQ_READ;
            endcase
        end
    endfunction

    // Position: mostly in range for the op, some at the range edges, some anywhere.
    function automatic logic [POS_W-1:0] rand_pos(logic [REQ_W-1:0] op);
        int unsigned hi;
        int          r;
        hi = (op == REQ_INS_POS) ? shadow_len + 1 : shadow_len;
        r  = $urandom_range(0, 99);
        if (r < 80 && hi >= 1)
        begin
            return POS_W'($urandom_range(1, hi));
        end
        else if (r < 90)
        begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return POS_W'(hi);
                2: return POS_W'(hi + 1);
                default: return POS_W'(hi + 2);
            endcase
        end
        else
        begin
            return POS_W'($urandom_range(0, 1023));
        end
    endfunction

    //------------------------------------------------------------------
    // Request driver
    //------------------------------------------------------------------
    // Offer one transaction and wait for it to be taken. The shadow list is updated
    // right at acceptance, so the next item is generated against the current count.
    task automatic send_req(logic [REQ_W-1:0] op, logic signed [VALUE_W-1:0] w,
                            logic [POS_W-1:0] pos, bit typed, list_rsp_t want);
        list_rsp_t predicted;
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= op;
        req_ch.value    <= w;
        req_ch.position <= pos;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = predict_list_op(op, w, pos);
        awaited_results.push_back(typed ? want : predicted);
    endtask

    // Bursts of back-to-back offers separated by idle gaps; a gap is never empty,
    // so valid is never dropped and raised in the same step.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 12);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_paced(logic [REQ_W-1:0] op, int unsigned pos);
        send_req(op, rand_word(), POS_W'(pos), 1'b0, '0);
        pace_sender();
    endtask

    task automatic send_random(int ins_pct);
        logic [REQ_W-1:0] op;
        op = pick_op(ins_pct);
        send_req(op, rand_word(), rand_pos(op), 1'b0, '0);
        pace_sender();
    endtask

    //------------------------------------------------------------------
    // Result checking
    //------------------------------------------------------------------
    task automatic note_mismatch(string msg);
        $display("MISMATCH @%0t result %0d: %s", $realtime, results_seen, msg);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        list_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                note_mismatch("result transaction with none outstanding");
            end
            else
            begin
                want = awaited_results.pop_front();
                if (rsp_ch.status !== want.status)
                    note_mismatch($sformatf("status %0d, want %0d", rsp_ch.status, want.status));
                if (rsp_ch.read_value !== want.read_value)
                    note_mismatch($sformatf("read_value %h, want %h",
                                            rsp_ch.read_value, want.read_value));
                if (rsp_ch.count !== want.count)
                    note_mismatch($sformatf("count %0d, want %0d", rsp_ch.count, want.count));
            end
            results_seen++;
        end
    end

    //------------------------------------------------------------------
    // Response receiver: picks a new ready pattern at random whenever the current one runs out,
    // and does one long hold-off on request from the stimulus.
    //------------------------------------------------------------------
    initial
    begin : rsp_sink
        int mode;
        int mode_left;
        rsp_ch.ready = 1'b0;
        mode         = RX_FREE;
        mode_left    = 0;
        forever
        begin
            @(posedge clk);
            if (hold_rsp_req)
            begin
                hold_rsp_req = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(RX_FREE, RX_PERIODIC);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (mode)
                RX_FREE:   rsp_ch.ready <= 1'b1;
                RX_RANDOM: rsp_ch.ready <= ($urandom_range(0, 99) < 60);
                default:   rsp_ch.ready <= (mode_left % 4 == 0);
            endcase
        end
    end

    //------------------------------------------------------------------
    // Watchdog: too many cycles without any transaction on either channel
    //------------------------------------------------------------------
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
    end

    //------------------------------------------------------------------
    // Stimulus
    //------------------------------------------------------------------
    initial
    begin : stimulus
        // Directed table, walked from reset. Hand-written expectations on the empty-list,
        // range-error, unused-code and most extreme-value rows; the rest use the shadow list.
        dir_tab = '{
            // deletes on an empty list report empty
            '{REQ_DEL_FRONT, 32'sh0,          10'd0,    1'b1, '{ST_EMPTY,  32'sh0,          9'd0}},
            '{REQ_DEL_BACK,  32'sh0,          10'd0,    1'b1, '{ST_EMPTY,  32'sh0,          9'd0}},
            // positional delete and read on an empty list are out of range
            '{REQ_DEL_POS,   32'sh0,          10'd1,    1'b1, '{ST_BADPOS, 32'sh0,          9'd0}},
            '{REQ_READ,      32'sh0,          10'd0,    1'b1, '{ST_BADPOS, 32'sh0,          9'd0}},
            // positional insert outside 1..count+1
            '{REQ_INS_POS,   32'sh1234_5678,  10'd0,    1'b1, '{ST_BADPOS, 32'sh0,          9'd0}},
            '{REQ_INS_POS,   32'sh1234_5678,  10'd2,    1'b1, '{ST_BADPOS, 32'sh0,          9'd0}},
            // build [7fffffff, 80000000, 0, ffffffff]
            '{REQ_INS_POS,   32'sh8000_0000,  10'd1,    1'b1, '{ST_OK,     32'sh0,          9'd1}},
            '{REQ_INS_FRONT, 32'sh7FFF_FFFF,  10'd0,    1'b1, '{ST_OK,     32'sh0,          9'd2}},
            '{REQ_INS_BACK,  32'sh0,          10'd1023, 1'b0, '{ST_OK,     32'sh0,          9'd0}},
            '{REQ_INS_BACK,  32'shFFFF_FFFF,  10'd0,    1'b1, '{ST_OK,     32'sh0,          9'd4}},
            '{REQ_READ,      32'sh0,          10'd1,    1'b1, '{ST_OK,     32'sh7FFF_FFFF,  9'd4}},
            '{REQ_READ,      32'sh0,          10'd4,    1'b1, '{ST_OK,     32'shFFFF_FFFF,  9'd4}},
            '{REQ_READ,      32'sh0,          10'd5,    1'b1, '{ST_BADPOS, 32'sh0,          9'd4}},
            // insert at count+1, then in the middle
            '{REQ_INS_POS,   32'sh5555_5555,  10'd5,    1'b0, '{ST_OK,     32'sh0,          9'd0}},
            '{REQ_INS_POS,   32'shAAAA_AAAA,  10'd2,    1'b0, '{ST_OK,     32'sh0,          9'd0}},
            '{REQ_READ,      32'sh0,          10'd1023, 1'b1, '{ST_BADPOS, 32'sh0,          9'd6}},
            // unused code changes nothing
            '{REQ_UNUSED,    32'shFFFF_FFFF,  10'd1,    1'b1, '{ST_OK,     32'sh0,          9'd6}},
            '{REQ_DEL_POS,   32'sh0,          10'd3,    1'b0, '{ST_OK,     32'sh0,          9'd0}},
            '{REQ_DEL_POS,   32'sh0,          10'd0,    1'b1, '{ST_BADPOS, 32'sh0,          9'd5}},
            '{REQ_DEL_POS,   32'sh0,          10'd5,    1'b0, '{ST_OK,     32'sh0,          9'd0}},
            '{REQ_DEL_FRONT, 32'sh0,          10'd0,    1'b0, '{ST_OK,     32'sh0,          9'd0}},
            '{REQ_DEL_BACK,  32'sh0,          10'd0,    1'b0, '{ST_OK,     32'sh0,          9'd0}},
            '{REQ_READ,      32'sh0,          10'd2,    1'b0, '{ST_OK,     32'sh0,          9'd0}},
            '{REQ_READ,      32'sh0,          10'd3,    1'b1, '{ST_BADPOS, 32'sh0,          9'd2}}
        };

        // Known values on every input from time zero.
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = '0;
        req_ch.value    = '0;
        req_ch.position = '0;
        shadow_len      = 0;
        mismatches      = 0;
        results_seen    = 0;
        burst_left      = 0;
        hold_rsp_req    = 1'b0;
        hold_done       = 1'b0;

        // Single reset at the start; the engine does no clearing pass after it.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            send_req(dir_tab[i].op, dir_tab[i].word, dir_tab[i].pos,
                     dir_tab[i].typed, dir_tab[i].want);
            pace_sender();
        end

        // Short mixed warm-up, leaning toward growth.
        repeat (30) send_random(60);

        // Fill to capacity with random inserts and some noise. Halfway up, the
        // receiver holds off for a long stretch while offers keep coming, so the
        // engine backs up and stalls its request side.
        while (shadow_len < CAPACITY)
        begin
            if (!hold_done && shadow_len >= CAPACITY / 2)
            begin
                hold_rsp_req = 1'b1;
                hold_done    = 1'b1;
            end
            send_random(88);
        end

        // Full list: every insert kind is refused, the range check wins over full,
        // and the last position is readable.
        send_paced(REQ_INS_FRONT, 1);
        send_paced(REQ_INS_BACK, 1);
        send_paced(REQ_INS_POS, shadow_len + 1);
        send_paced(REQ_INS_POS, shadow_len);
        send_paced(REQ_INS_POS, shadow_len + 2);
        send_paced(REQ_INS_POS, 0);
        send_paced(REQ_READ, CAPACITY);
        send_paced(REQ_READ, CAPACITY + 1);

        // Let everything outstanding come back before going on.
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0) @(posedge clk);

        // Drain part of the way down, mostly deletes.
        while (shadow_len > 176) send_random(10);

        // Mixed tail.
        repeat (40) send_random(45);

        // Wait for the last results, then watch a little longer for strays.
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
